@@ hw/rtl/omt_pkg.sv @@
// ----------------------------------------------------------------------------
// omt_pkg: shared types and codes for the ordered multiset table
// Operation codes, key and count widths, sequencer phases and the cell
// broadcast struct.
// ----------------------------------------------------------------------------
package omt_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;   // unused code, acts as a query

    localparam int KEY_BITS   = 32;
    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // sequencer phases of one item
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_UPDATE,
        PH_MERGE,
        PH_LOAD
    } omt_phase_t;

    // what each cell does this cycle
    typedef struct packed {
        logic do_ins;   // insert a new key: cells at/above rank shift up
        logic do_bump;  // matched cell increments its count
        logic do_dec;   // matched cell decrements its count
        logic do_del;   // matched cell removed: cells above shift down
    } cell_cmd_t;

endpackage

@@ hw/rtl/omt_cell.sv @@
// ----------------------------------------------------------------------------
// omt_cell: one slot of the sorted chain
// Holds a key and a count; compares against the broadcast key and shifts.
// ----------------------------------------------------------------------------
module omt_cell
    import omt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic signed [KEY_BITS-1:0] key,
    input  cell_cmd_t                  cmd,
    input  logic                       lower_valid,
    input  logic signed [KEY_BITS-1:0] lower_key,
    input  logic [COUNT_BITS-1:0]      lower_count,
    input  logic                       lower_below,
    input  logic                       upper_valid,
    input  logic signed [KEY_BITS-1:0] upper_key,
    input  logic [COUNT_BITS-1:0]      upper_count,
    input  logic                       upper_match,
    input  logic                       upper_below,
    output logic                       valid,
    output logic signed [KEY_BITS-1:0] cell_key,
    output logic [COUNT_BITS-1:0]      cell_count,
    output logic                       below,
    output logic                       match
);

    logic                       valid_reg, valid_next;
    logic signed [KEY_BITS-1:0] key_reg, key_next;
    logic [COUNT_BITS-1:0]      count_reg, count_next;

    assign below = valid_reg && (key_reg < key);
    assign match = valid_reg && (key_reg == key);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        count_next = count_reg;
        if (cmd.do_ins && !below)
        begin
            if (lower_below)
            begin
                // insertion point (first slot at or above rank)
                valid_next = 1'b1;
                key_next   = key;
                count_next = COUNT_BITS'(1);
            end
            else
            begin
                valid_next = lower_valid;
                key_next   = lower_key;
                count_next = lower_count;
            end
        end
        else if (cmd.do_bump && match && count_reg != COUNT_MAX)
            count_next = count_reg + COUNT_BITS'(1);
        else if (cmd.do_dec && match)
            count_next = count_reg - COUNT_BITS'(1);
        else if (cmd.do_del && (match || !below) && !upper_below && valid_reg)
        begin
            if (match || !upper_match)
            begin
                valid_next = upper_valid;
                key_next   = upper_key;
                count_next = upper_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_next;
    end

    assign valid      = valid_reg;
    assign cell_key   = key_reg;
    assign cell_count = count_reg;

endmodule

@@ hw/rtl/omt_merge.sv @@
// ----------------------------------------------------------------------------
// omt_merge: registered answer stage over the chain
// Finds predecessor (last cell below key) and matched count and registers both.
// ----------------------------------------------------------------------------
module omt_merge
    import omt_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic                       clk,
    input  logic [CAPACITY-1:0]        below,
    input  logic [CAPACITY-1:0]        match,
    input  logic [KEY_BITS-1:0]        keys  [CAPACITY],
    input  logic [COUNT_BITS-1:0]      counts[CAPACITY],
    output logic                       pred_valid,
    output logic [KEY_BITS-1:0]        pred_key,
    output logic                       hit,
    output logic [COUNT_BITS-1:0]      hit_count
);

    // The chain is sorted, so the predecessor is the cell whose below bit is
    // set while its upper neighbor's is clear. At most one cell qualifies, so
    // an OR reduction of masked values suffices.
    logic [KEY_BITS-1:0]   pk_reg;
    logic [COUNT_BITS-1:0] hc_reg;
    logic                  pv_reg, hit_reg;
    logic [KEY_BITS-1:0]   pk_next;
    logic [COUNT_BITS-1:0] hc_next;
    logic                  edge_bit;

    always_comb
    begin
        pk_next  = '0;
        hc_next  = '0;
        edge_bit = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            edge_bit = below[i] && ((i == CAPACITY - 1) ? 1'b1 : !below[(i + 1) % CAPACITY]);
            pk_next  = pk_next | (edge_bit ? keys[i] : '0);
            hc_next  = hc_next | (match[i] ? counts[i] : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        pk_reg  <= pk_next;
        hc_reg  <= hc_next;
        pv_reg  <= |below;
        hit_reg <= |match;
    end

    assign pred_valid = pv_reg;
    assign pred_key   = pk_reg;
    assign hit        = hit_reg;
    assign hit_count  = hc_reg;

endmodule

@@ hw/rtl/ordered_multiset_table.sv @@
// ----------------------------------------------------------------------------
// ordered_multiset_table: sorted multiset of signed keys with counts
// ----------------------------------------------------------------------------
// A chain of CAPACITY cells holds the distinct keys in ascending order with
// their counts. One item is in flight at a time. After the accepting edge the
// update cycle broadcasts the key, every cell compares at once and the chain
// shifts up (insert) or down (delete of the last copy) by one slot; the merge
// cycle registers the predecessor and the key's count; the load cycle moves
// the result beat into the output register. The sequencer is then idle
// again and takes the next beat at the following edge; it takes no new item
// before the last one has reached the output register. The input is taken
// even while a result still waits; only the load cycle of the next item
// stalls until the waiting result beat has been taken.
// ----------------------------------------------------------------------------
module ordered_multiset_table
    import omt_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // op[1:0], key[33:2], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // success, key_count[16:1], min_valid,
                                   // min_key[49:18], pred_valid, pred_key[82:51],
                                   // table_full, zero fill
);

    localparam int OCC_BITS = $clog2(CAPACITY + 1);

    omt_phase_t                 phase_reg, phase_next;
    logic [1:0]                 op_reg;
    logic signed [KEY_BITS-1:0] key_reg;
    logic                       succ_reg;
    logic [OCC_BITS-1:0]        occ_reg, occ_next;
    logic                       out_v_reg, out_v_next;
    logic [87:0]                out_reg;
    logic                       load_out;

    logic [CAPACITY-1:0]   cv, cb, cm;
    logic [KEY_BITS-1:0]   ck[CAPACITY];
    logic [COUNT_BITS-1:0] cc[CAPACITY];
    cell_cmd_t             cmd;
    logic                  present, full, cnt_one, is_ins, is_del;

    assign present = |cm;
    assign full    = occ_reg == OCC_BITS'(CAPACITY);
    assign is_ins  = op_reg == OP_INSERT;
    assign is_del  = op_reg == OP_DELETE;

    always_comb
    begin
        cnt_one = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
            cnt_one = cnt_one | (cm[i] && cc[i] == COUNT_BITS'(1));
    end

    always_comb
    begin
        cmd = '0;
        if (phase_reg == PH_UPDATE)
        begin
            cmd.do_ins  = is_ins && !present && !full;
            cmd.do_bump = is_ins && present;
            cmd.do_dec  = is_del && present && !cnt_one;
            cmd.do_del  = is_del && present && cnt_one;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        omt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .key        (key_reg),
            .cmd        (cmd),
            .lower_valid(g == 0 ? 1'b0 : cv[(g + CAPACITY - 1) % CAPACITY]),
            .lower_key  (ck[(g + CAPACITY - 1) % CAPACITY]),
            .lower_count(cc[(g + CAPACITY - 1) % CAPACITY]),
            .lower_below(g == 0 ? 1'b1 : cb[(g + CAPACITY - 1) % CAPACITY]),
            .upper_valid(g == CAPACITY - 1 ? 1'b0 : cv[(g + 1) % CAPACITY]),
            .upper_key  (ck[(g + 1) % CAPACITY]),
            .upper_count(cc[(g + 1) % CAPACITY]),
            .upper_match(g == CAPACITY - 1 ? 1'b0 : cm[(g + 1) % CAPACITY]),
            .upper_below(g == CAPACITY - 1 ? 1'b0 : cb[(g + 1) % CAPACITY]),
            .valid      (cv[g]),
            .cell_key   (ck[g]),
            .cell_count (cc[g]),
            .below      (cb[g]),
            .match      (cm[g])
        );
    end

    logic                  pv, hit;
    logic [KEY_BITS-1:0]   pk;
    logic [COUNT_BITS-1:0] hc;

    omt_merge #(.CAPACITY(CAPACITY)) u_merge (
        .clk       (clk),
        .below     (cb),
        .match     (cm),
        .keys      (ck),
        .counts    (cc),
        .pred_valid(pv),
        .pred_key  (pk),
        .hit       (hit),
        .hit_count (hc)
    );

    // load only when the output register is free or being emptied this edge
    assign load_out = phase_reg == PH_LOAD && (!out_v_reg || m_tready);
    assign s_tready = phase_reg == PH_IDLE;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:   if (s_tvalid && s_tready) phase_next = PH_UPDATE;
            PH_UPDATE: phase_next = PH_MERGE;
            PH_MERGE:  phase_next = PH_LOAD;   // merge stage settles on new chain
            PH_LOAD:   if (load_out) phase_next = PH_IDLE;
            default:   phase_next = PH_IDLE;
        endcase
    end

    always_comb
    begin
        occ_next   = occ_reg;
        out_v_next = out_v_reg && !m_tready;
        if (cmd.do_ins)
            occ_next = occ_reg + OCC_BITS'(1);
        if (cmd.do_del)
            occ_next = occ_reg - OCC_BITS'(1);
        if (load_out)
            out_v_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            occ_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            occ_reg   <= occ_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg  <= s_tdata[1:0];
            key_reg <= s_tdata[33:2];
        end
        if (phase_reg == PH_UPDATE)
            succ_reg <= !((is_ins && !present && full) || (is_del && !present));
        if (load_out)
            out_reg <= {4'd0, full, pv ? pk : KEY_BITS'(0), pv,
                        cv[0] ? ck[0] : KEY_BITS'(0), cv[0],
                        hit ? hc : COUNT_BITS'(0), succ_reg};
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

endmodule

@@ hw/rtl/omt_checker.sv @@
// ----------------------------------------------------------------------------
// omt_checker: port-level checks for the ordered multiset table
// Watches handshake and result consistency.
// ----------------------------------------------------------------------------
module omt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);

    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: no second beat right after an accepted one
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // a failed op never reports a count
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'd0)
        else $error("count on failed op");

    // an empty table has no predecessor
    a_pred: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[17] |-> !m_tdata[50])
        else $error("predecessor in empty table");

endmodule

bind ordered_multiset_table omt_checker u_omt_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

@@ tb/sv/tb_ordered_multiset_table.sv @@
// ----------------------------------------------------------------------------
// tb_ordered_multiset_table: self-checking bench for the ordered multiset table
// Drives insert/delete/query beats with random gaps on both streams, predicts
// every result beat from a local sorted-table model, and compares each field.
// ----------------------------------------------------------------------------
module tb_ordered_multiset_table;
    import omt_pkg::*;

    localparam int CAP       = 1024;
    localparam int LIMIT     = 400000;
    localparam int CNT_LIMIT = 65535;

    // lowest field last, matching the result beat packing
    typedef struct packed {
        logic        table_full;
        logic [31:0] pred_key;
        logic        pred_valid;
        logic [31:0] min_key;
        logic        min_valid;
        logic [15:0] key_count;
        logic        success;
    } omt_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // op[1:0], key[33:2], zero fill
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // success, key_count, min_valid, min_key,
                            // pred_valid, pred_key, table_full, zero fill

    ordered_multiset_table #(.CAPACITY(CAP)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor state: sorted distinct keys with counts
    logic signed [31:0] tbl_keys[$];
    int unsigned        tbl_counts[$];
    omt_result_t        pending_results[$];

    int  errors;
    int  cycles;
    int  beats_sent;
    int  beats_checked;
    int  full_hits;
    bit  mostly_dense;   // random output stalls mostly short

    // -- predictor ------------------------------------------------------------
    function automatic omt_result_t apply_op(logic [1:0] op, logic signed [31:0] key);
        omt_result_t r;
        int          pos;
        bit          present;
        pos = 0;
        while (pos < tbl_keys.size() && tbl_keys[pos] < key)
            pos++;
        present = pos < tbl_keys.size() && tbl_keys[pos] == key;
        r = '0;
        r.success = 1'b1;
        if (op == OP_INSERT) begin
            if (present) begin
                if (tbl_counts[pos] < CNT_LIMIT)
                    tbl_counts[pos]++;
            end else if (tbl_keys.size() < CAP) begin
                tbl_keys.insert(pos, key);
                tbl_counts.insert(pos, 1);
                present = 1'b1;
            end else begin
                r.success = 1'b0;
                full_hits++;
            end
        end else if (op == OP_DELETE) begin
            if (!present)
                r.success = 1'b0;
            else if (tbl_counts[pos] > 1)
                tbl_counts[pos]--;
            else begin
                tbl_keys.delete(pos);
                tbl_counts.delete(pos);
                present = 1'b0;
            end
        end
        if (present)
            r.key_count = tbl_counts[pos][15:0];
        r.min_valid  = tbl_keys.size() > 0;
        r.min_key    = r.min_valid ? tbl_keys[0] : '0;
        r.pred_valid = pos > 0;
        r.pred_key   = pos > 0 ? tbl_keys[pos-1] : '0;
        r.table_full = tbl_keys.size() >= CAP;
        return r;
    endfunction

    // -- stimulus side --------------------------------------------------------
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic send_beat(logic [1:0] op, logic [31:0] key, bit gaps = 1);
        int gap;
        gap = gaps ? pick_gap() : 0;
        repeat (gap) @(negedge clk);
        s_tdata  = {6'd0, key, op};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(apply_op(op, key));
        beats_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] stored_key();
        if (tbl_keys.size() == 0)
            return $urandom();
        return tbl_keys[$urandom_range(0, tbl_keys.size() - 1)];
    endfunction

    // extremes, every op, the unused op code, absent delete, last-copy removal
    task automatic test_directed();
        send_beat(OP_QUERY, 32'h8000_0000);
        send_beat(OP_DELETE, 32'd5);
        send_beat(OP_INSERT, 32'd0);
        send_beat(OP_INSERT, 32'h7FFF_FFFF);
        send_beat(OP_INSERT, 32'h8000_0000);
        send_beat(OP_INSERT, 32'hFFFF_FFFF);
        send_beat(OP_INSERT, 32'd0);
        send_beat(OP_QUERY, 32'h7FFF_FFFF);
        send_beat(OP_QUERY, 32'd1);
        send_beat(OP_SPARE, 32'h8000_0001);
        send_beat(OP_DELETE, 32'd0);
        send_beat(OP_DELETE, 32'd0);
        send_beat(OP_DELETE, 32'd0);
        send_beat(OP_DELETE, 32'h8000_0000);
        send_beat(OP_QUERY, 32'h5555_5555);
        send_beat(OP_QUERY, 32'hAAAA_AAAA);
        send_beat(OP_DELETE, 32'h7FFF_FFFF);
        send_beat(OP_DELETE, 32'hFFFF_FFFF);
        send_beat(OP_QUERY, 32'd0);
        // pressure: hold the sender until every result is back
        wait_drained();
    endtask

    // random mix, keys drawn from a narrow pool or from stored keys so they repeat, some fully random
    task automatic test_random(int n);
        logic [1:0]  op;
        logic [31:0] key;
        int          sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            op  = sel < 4 ? OP_INSERT : sel < 7 ? OP_DELETE :
                  sel < 9 ? OP_QUERY : OP_SPARE;
            case ($urandom_range(0, 3))
                0:       key = $urandom();
                1:       key = stored_key();
                default: key = $signed($urandom_range(0, 40)) - 20;
            endcase
            if (i == n / 2)
                wait_drained();
            send_beat(op, key, i % 200 < 150);
        end
    endtask

    // fill to capacity, probe the full table, then empty part of it
    task automatic test_full_table();
        while (tbl_keys.size() < CAP)
            send_beat(OP_INSERT, $urandom(), 0);
        send_beat(OP_INSERT, $urandom() | 32'h1);
        send_beat(OP_INSERT, tbl_keys[5]);
        send_beat(OP_QUERY, 32'h7FFF_FFFF);
        send_beat(OP_DELETE, tbl_keys[CAP-1]);
        send_beat(OP_INSERT, 32'h8000_0000);
        send_beat(OP_INSERT, 32'h0BAD_0001);
        for (int i = 0; i < 40; i++)
            send_beat(OP_DELETE, stored_key());
    endtask

    // -- result side ----------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (mostly_dense || $urandom_range(0, 3) != 0)
            m_tready <= $urandom_range(0, 99) < 80;
        else
            m_tready <= $urandom_range(0, 99) < 15;
    end

    always @(posedge clk)
    begin
        omt_result_t got;
        omt_result_t want;
        cycles++;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata[83:0];
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, got %h", $time, got);
            end else begin
                want = pending_results.pop_front();
                beats_checked++;
                if (got.success !== want.success)
                    $display("%0t: success exp %0d got %0d", $time, want.success, got.success);
                if (got.key_count !== want.key_count)
                    $display("%0t: key_count exp %0d got %0d", $time, want.key_count,
                             got.key_count);
                if (got.min_valid !== want.min_valid)
                    $display("%0t: min_valid exp %0d got %0d", $time, want.min_valid,
                             got.min_valid);
                if (got.min_key !== want.min_key)
                    $display("%0t: min_key exp %h got %h", $time, want.min_key, got.min_key);
                if (got.pred_valid !== want.pred_valid)
                    $display("%0t: pred_valid exp %0d got %0d", $time, want.pred_valid,
                             got.pred_valid);
                if (got.pred_key !== want.pred_key)
                    $display("%0t: pred_key exp %h got %h", $time, want.pred_key, got.pred_key);
                if (got.table_full !== want.table_full)
                    $display("%0t: table_full exp %0d got %0d", $time, want.table_full,
                             got.table_full);
                if (got !== want)
                    errors++;
            end
        end
        if (cycles > LIMIT * 2) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int tail;
        errors        = 0;
        cycles        = 0;
        beats_sent    = 0;
        beats_checked = 0;
        full_hits     = 0;
        mostly_dense  = 0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(150);
        mostly_dense = 1;
        test_full_table();
        mostly_dense = 0;
        test_random(60);

        tail = 0;
        while (pending_results.size() != 0 && tail < 20000) begin
            @(negedge clk);
            tail++;
        end
        repeat (20) @(negedge clk);
        if (pending_results.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end

        $display("covered %0d beats (%0d checked), %0d refused inserts on a full table,",
                 beats_sent, beats_checked, full_hits);
        $display("key extremes, the unused op code and last-copy deletes under random stalls");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
